// ===== hdl/hstd_pkg.sv =====
// ----------------------------------------------------------------------------
// hstd_pkg: shared definitions for the header/sum/tail deframer
// Frame geometry, field widths, register indexes, and the command and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package hstd_pkg;

    // frame geometry
    localparam int HEADER_LEN = 2;
    localparam int FRAME_LEN  = 32;

    localparam int BYTE_W     = 8;
    localparam int POS_W      = $clog2(FRAME_LEN);
    localparam int BYTE_POS_W = 6;
    localparam int HDR_REG_W  = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // key frame positions
    localparam logic [POS_W-1:0] LEN_POS  = POS_W'(HEADER_LEN);
    localparam logic [POS_W-1:0] ID_POS   = POS_W'(HEADER_LEN + 1);
    localparam logic [POS_W-1:0] SUM_POS  = POS_W'(FRAME_LEN - 2);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    localparam logic [BYTE_W-1:0] LEN_BYTE = BYTE_W'(FRAME_LEN);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_PATTERN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE      = CFG_IDX_W'(1);

    // controller -> datapath
    typedef struct packed {
        logic             accept;     // input channel open
        logic             rd_en;      // issue frame store read
        logic [POS_W-1:0] rd_addr;
        logic             load_out;   // read data arrives, load output register
        logic [POS_W-1:0] load_addr;  // position of the arriving byte
    } hstd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic frame_good;             // accepted byte closes a valid frame
    } hstd_sts_t;

endpackage

// ===== hdl/hstd_in_if.sv =====
// ----------------------------------------------------------------------------
// hstd_in_if: received byte channel
// Valid/ready channel carrying one serial byte per transaction.
// ----------------------------------------------------------------------------
interface hstd_in_if;
    import hstd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== hdl/hstd_out_if.sv =====
// ----------------------------------------------------------------------------
// hstd_out_if: validated frame byte channel
// Valid/ready channel carrying one frame byte with its position and tag.
// ----------------------------------------------------------------------------
interface hstd_out_if;
    import hstd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [BYTE_W-1:0]     out_byte;
    logic [BYTE_POS_W-1:0] byte_pos;
    logic [BYTE_W-1:0]     frame_tag;
    logic                  last;

    modport source (output valid, output out_byte, output byte_pos, output frame_tag,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input byte_pos, input frame_tag,
                    input last, output ready);
endinterface

// ===== hdl/hstd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// hstd_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface hstd_cfg_if;
    import hstd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/hstd_ram.sv =====
// ----------------------------------------------------------------------------
// hstd_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hstd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/hstd_dp.sv =====
// ----------------------------------------------------------------------------
// hstd_dp: deframer datapath
// Frame position tracking, header/length checks, running sum, frame store,
// configuration registers and the output payload register.
// ----------------------------------------------------------------------------
module hstd_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [hstd_pkg::BYTE_W-1:0]     in_byte,
    input  logic                            cfg_valid,
    input  logic [hstd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hstd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  hstd_pkg::hstd_cmd_t             cmd,
    output hstd_pkg::hstd_sts_t             sts,
    output logic [hstd_pkg::BYTE_W-1:0]     out_byte,
    output logic [hstd_pkg::BYTE_POS_W-1:0] byte_pos,
    output logic [hstd_pkg::BYTE_W-1:0]     frame_tag,
    output logic                            last
);
    import hstd_pkg::*;

    logic [POS_W-1:0]     position_reg, position_next;
    logic [BYTE_W-1:0]    sum_reg, sum_next;
    logic [BYTE_W-1:0]    tag_reg, tag_next;
    logic                 sum_ok_reg, sum_ok_next;
    logic [HDR_REG_W-1:0] header_pattern_reg;
    logic [BYTE_W-1:0]    tail_byte_reg;

    logic [BYTE_W-1:0]    out_byte_reg;
    logic [BYTE_POS_W-1:0] byte_pos_reg;
    logic [BYTE_W-1:0]    frame_tag_reg;
    logic                 last_reg;

    logic                 take;
    logic                 store_we;
    logic                 good;
    logic [BYTE_W-1:0]    exp_byte;
    logic [BYTE_W-1:0]    rd_data;

    assign take = in_valid && cmd.accept;

    // expected header byte; bytes beyond the 16-bit register are zero
    always_comb
    begin
        exp_byte = '0;
        if (position_reg == POS_W'(0))
        begin
            exp_byte = header_pattern_reg[BYTE_W-1:0];
        end
        else if (position_reg == POS_W'(1))
        begin
            exp_byte = header_pattern_reg[2*BYTE_W-1:BYTE_W];
        end
    end

    always_comb
    begin
        position_next = position_reg;
        sum_next      = sum_reg;
        tag_next      = tag_reg;
        sum_ok_next   = sum_ok_reg;
        store_we      = 1'b0;
        good          = 1'b0;
        if (take)
        begin
            if (position_reg < LEN_POS)
            begin
                if (in_byte == exp_byte)
                begin
                    store_we      = 1'b1;
                    position_next = position_reg + POS_W'(1);
                    sum_next      = ((position_reg == POS_W'(0)) ? '0 : sum_reg) + in_byte;
                end
                else
                begin
                    position_next = '0;
                end
            end
            else if ((position_reg == LEN_POS) && (in_byte != LEN_BYTE))
            begin
                position_next = '0;
            end
            else
            begin
                store_we = 1'b1;
                if (position_reg == ID_POS)
                begin
                    tag_next = in_byte;
                end
                if (position_reg < SUM_POS)
                begin
                    sum_next = sum_reg + in_byte;
                end
                if (position_reg == SUM_POS)
                begin
                    sum_ok_next = (in_byte == sum_reg);
                end
                if (position_reg == LAST_POS)
                begin
                    position_next = '0;
                    good          = sum_ok_reg && (in_byte == tail_byte_reg);
                end
                else
                begin
                    position_next = position_reg + POS_W'(1);
                end
            end
        end
    end

    assign sts.frame_good = good;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg       <= '0;
            sum_reg            <= '0;
            tag_reg            <= '0;
            sum_ok_reg         <= 1'b0;
            header_pattern_reg <= '0;
            tail_byte_reg      <= '0;
        end
        else
        begin
            position_reg <= position_next;
            sum_reg      <= sum_next;
            tag_reg      <= tag_next;
            sum_ok_reg   <= sum_ok_next;
            if (cfg_valid && (cfg_index == REG_HEADER_PATTERN))
            begin
                header_pattern_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == REG_TAIL_BYTE))
            begin
                tail_byte_reg <= cfg_data[BYTE_W-1:0];
            end
        end
    end

    hstd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_LEN)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (store_we),
        .wr_addr (position_reg),
        .wr_data (in_byte),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_data)
    );

    // output payload, loaded as read data comes back
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_byte_reg  <= rd_data;
            byte_pos_reg  <= BYTE_POS_W'(cmd.load_addr);
            frame_tag_reg <= tag_reg;
            last_reg      <= (cmd.load_addr == LAST_POS);
        end
    end

    assign out_byte  = out_byte_reg;
    assign byte_pos  = byte_pos_reg;
    assign frame_tag = frame_tag_reg;
    assign last      = last_reg;

endmodule

// ===== hdl/hstd_ctrl.sv =====
// ----------------------------------------------------------------------------
// hstd_ctrl: deframer controller
// Receive/emit state machine, frame store read sequencing and output valid.
// ----------------------------------------------------------------------------
module hstd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_ready,
    input  hstd_pkg::hstd_sts_t sts,
    output hstd_pkg::hstd_cmd_t cmd,
    output logic                out_valid
);
    import hstd_pkg::*;

    typedef enum logic [1:0] {
        ST_RECV = 2'b01,
        ST_EMIT = 2'b10
    } hstd_state_t;

    hstd_state_t      state_reg, state_next;
    logic [POS_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic [POS_W-1:0] ld_addr_reg, ld_addr_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    logic             rd_issue;

    // one read in flight; issue only when the output slot is free at arrival
    assign rd_issue = (state_reg == ST_EMIT) && !pend_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        cmd.accept    = (state_reg == ST_RECV);
        cmd.rd_en     = rd_issue;
        cmd.rd_addr   = rd_cnt_reg;
        cmd.load_out  = pend_reg;
        cmd.load_addr = ld_addr_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        rd_cnt_next    = rd_cnt_reg;
        ld_addr_next   = ld_addr_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;

        if (pend_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_RECV:
            begin
                if (in_valid && sts.frame_good)
                begin
                    state_next  = ST_EMIT;
                    rd_cnt_next = '0;
                    pend_next   = 1'b0;
                end
            end
            ST_EMIT:
            begin
                if (rd_issue)
                begin
                    rd_cnt_next  = rd_cnt_reg + POS_W'(1);
                    ld_addr_next = rd_cnt_reg;
                    pend_next    = 1'b1;
                end
                if (pend_reg)
                begin
                    pend_next = 1'b0;
                    if (ld_addr_reg == LAST_POS)
                    begin
                        state_next = ST_RECV;
                    end
                end
            end
            default:
            begin
                state_next = ST_RECV;
                pend_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RECV;
            rd_cnt_reg    <= '0;
            ld_addr_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            ld_addr_reg   <= ld_addr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/header_sum_tail_deframer_core.sv =====
// Output path: once the byte that closes a good frame is taken, the controller enters
//   replay, issues a frame store read, then loads the output register and sets valid.
// Throughput: 1 input byte per cycle while receiving; a good frame then streams
//   out byte by byte (one frame store read in flight), input held off.
// Reset (rst_n, async, active low): hunting the header, sum and tag cleared,
//   both configuration registers zero, output empty. No memory clearing pass.
// ----------------------------------------------------------------------------
// header_sum_tail_deframer_core: serial frame deframer with additive checksum
// Hunts a configured header, checks the length byte, captures the frame id, checks
// the 8-bit sum and tail byte, and replays good frames byte by byte.
// ----------------------------------------------------------------------------
module header_sum_tail_deframer_core (
    input  logic       clk,
    input  logic       rst_n,
    hstd_in_if.sink    in_ch,
    hstd_out_if.source out_ch,
    hstd_cfg_if.sink   cfg_ch
);
    import hstd_pkg::*;

    hstd_cmd_t cmd;
    hstd_sts_t sts;

    // Configuration is always taken; the datapath decodes the index and
    // ignores writes beyond the register list.
    assign cfg_ch.ready = 1'b1;

    // Input is open only while receiving. During replay the frame store is
    // being read out and the byte position is parked at zero.
    assign in_ch.ready = cmd.accept;

    // Controller: receive/emit sequencing, read issue, output valid.
    hstd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd),
        .out_valid (out_ch.valid)
    );

    // Datapath: frame checks, frame store, output payload register.
    hstd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_byte   (in_ch.in_byte),
        .cfg_valid (cfg_ch.valid),
        .cfg_index (cfg_ch.index),
        .cfg_data  (cfg_ch.data),
        .cmd       (cmd),
        .sts       (sts),
        .out_byte  (out_ch.out_byte),
        .byte_pos  (out_ch.byte_pos),
        .frame_tag (out_ch.frame_tag),
        .last      (out_ch.last)
    );

`ifndef SYNTHESIS
    // the end-of-frame flag only rides on the final frame position
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.last) |-> (out_ch.byte_pos == BYTE_POS_W'(FRAME_LEN - 1)))
        else $error("last flag on wrong byte position");

    // a completed good frame closes the input as replay starts
    a_good_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && sts.frame_good) |=> !in_ch.ready)
        else $error("input open right after a good frame");

    // mid-frame output transaction: replay still running, input stays closed
    a_replay_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && !out_ch.last) |=> !in_ch.ready)
        else $error("input reopened before frame replay finished");
`endif

endmodule
